// ===== hdl/pq_pkg.sv =====
// Shared types and constants for the palette color quantizer.
// Used by the cell, the top level and the port checker; depends on nothing.
package pq_pkg;

	localparam int PALETTE_ENTRIES = 8;
	localparam int CHAN_W          = 8;
	localparam int IDX_W           = 3;
	localparam int DIST_W          = 18;
	localparam int ENTRY_W         = 43;
	localparam int CFG_IDX_W       = 4;
	localparam int COLOR_W         = 3 * CHAN_W;
	localparam int LATENCY         = 2 * PALETTE_ENTRIES + 1;

	// Entry register layout.
	localparam int RED_LSB   = 0;
	localparam int GREEN_LSB = 8;
	localparam int BLUE_LSB  = 16;
	localparam int THR_LSB   = 24;
	localparam int VALID_BIT = 42;

	typedef struct packed {
		logic [CHAN_W-1:0] pixel_blue;
		logic [CHAN_W-1:0] pixel_green;
		logic [CHAN_W-1:0] pixel_red;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_red;
		logic [IDX_W-1:0]  chosen_index;
		logic              fell_back;
	} result_t;

	// What one request carries from cell to cell.
	typedef struct packed {
		logic               valid;
		pixel_t             pixel;
		logic [DIST_W-1:0]  best_d;
		logic [IDX_W-1:0]   best_idx;
		logic [DIST_W-1:0]  best_thr;
		logic [COLOR_W-1:0] best_color;
		logic [COLOR_W-1:0] base_color;
	} link_t;

endpackage

// ===== hdl/pq_cell.sv =====
// One palette cell: holds one entry and compares the passing pixel against it.
// Depends on pq_pkg.
module pq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [pq_pkg::ENTRY_W-1:0]    wr_data,
	input  logic                          anchor,
	input  logic [pq_pkg::IDX_W-1:0]      my_index,
	input  pq_pkg::link_t                 link_in,
	output pq_pkg::link_t                 link_out
);

	logic [pq_pkg::ENTRY_W-1:0] entry_q;
	logic [pq_pkg::CHAN_W-1:0]  e_red;
	logic [pq_pkg::CHAN_W-1:0]  e_green;
	logic [pq_pkg::CHAN_W-1:0]  e_blue;
	logic [pq_pkg::CHAN_W-1:0]  d_red;
	logic [pq_pkg::CHAN_W-1:0]  d_green;
	logic [pq_pkg::CHAN_W-1:0]  d_blue;
	logic [2*pq_pkg::CHAN_W-1:0] sq_red_s1;
	logic [2*pq_pkg::CHAN_W-1:0] sq_green_s1;
	logic [2*pq_pkg::CHAN_W-1:0] sq_blue_s1;
	pq_pkg::link_t              link_s1;
	pq_pkg::link_t              link_s2;
	logic [pq_pkg::DIST_W-1:0]  sq_dist;
	logic                       searched;
	logic                       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr_en) begin
			entry_q <= wr_data;
		end
	end

	assign e_red   = entry_q[pq_pkg::RED_LSB   +: pq_pkg::CHAN_W];
	assign e_green = entry_q[pq_pkg::GREEN_LSB +: pq_pkg::CHAN_W];
	assign e_blue  = entry_q[pq_pkg::BLUE_LSB  +: pq_pkg::CHAN_W];

	always_comb begin
		d_red   = (link_in.pixel.pixel_red > e_red) ? link_in.pixel.pixel_red - e_red
			: e_red - link_in.pixel.pixel_red;
		d_green = (link_in.pixel.pixel_green > e_green) ? link_in.pixel.pixel_green - e_green
			: e_green - link_in.pixel.pixel_green;
		d_blue  = (link_in.pixel.pixel_blue > e_blue) ? link_in.pixel.pixel_blue - e_blue
			: e_blue - link_in.pixel.pixel_blue;
	end

	// First half: the three channel squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1     <= '0;
			sq_red_s1   <= '0;
			sq_green_s1 <= '0;
			sq_blue_s1  <= '0;
		end else begin
			link_s1     <= link_in;
			sq_red_s1   <= d_red * d_red;
			sq_green_s1 <= d_green * d_green;
			sq_blue_s1  <= d_blue * d_blue;
		end
	end

	// Second half: sum, compare and keep the better entry. Only a strictly
	// smaller distance wins, so ties stay with the lower index.
	assign sq_dist = pq_pkg::DIST_W'(sq_red_s1) + pq_pkg::DIST_W'(sq_green_s1)
		+ pq_pkg::DIST_W'(sq_blue_s1);
	assign searched = anchor | entry_q[pq_pkg::VALID_BIT];
	assign take     = searched && (sq_dist < link_s1.best_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s2 <= '0;
		end else begin
			link_s2.valid <= link_s1.valid;
			link_s2.pixel <= link_s1.pixel;
			if (take) begin
				link_s2.best_d     <= sq_dist;
				link_s2.best_idx   <= my_index;
				link_s2.best_thr   <= entry_q[pq_pkg::THR_LSB +: pq_pkg::DIST_W];
				link_s2.best_color <= entry_q[pq_pkg::COLOR_W-1:0];
			end else begin
				link_s2.best_d     <= link_s1.best_d;
				link_s2.best_idx   <= link_s1.best_idx;
				link_s2.best_thr   <= link_s1.best_thr;
				link_s2.best_color <= link_s1.best_color;
			end
			if (anchor) begin
				link_s2.base_color <= entry_q[pq_pkg::COLOR_W-1:0];
			end else begin
				link_s2.base_color <= link_s1.base_color;
			end
		end
	end

	assign link_out = link_s2;

endmodule

// ===== hdl/palette_color_quantizer.sv =====
// Top level of the palette color quantizer: a chain of pq_cell instances and
// the final threshold stage. Depends on pq_pkg and pq_cell.
//
//   channel   signals                              direction  handshake
//   request   start, busy, pixel                   in         start && !busy
//   result    done, result                         out        done strobe, one cycle
//   config    cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//             cfg_data
//
// A pixel enters every clock cycle; busy is never raised. Each result passes
// through two register stages per cell (channel squares, then sum and
// compare) and one output stage for the threshold test. Reset clears all
// entry registers and every valid flag in the chain. The result side has no
// back-pressure, and nothing in the chain ever stalls.
module palette_color_quantizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  pq_pkg::pixel_t                   pixel,
	output logic                             done,
	output pq_pkg::result_t                  result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pq_pkg::ENTRY_W-1:0]       cfg_data
);

	pq_pkg::link_t             link [0:pq_pkg::PALETTE_ENTRIES];
	logic                      fall;
	logic                      done_q;
	pq_pkg::result_t           result_q;

	// The chain never holds back a request, and registers are always writable.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// The head of the chain starts with a distance larger than any real one,
	// so entry 0, which is always searched, is certain to take the lead.
	always_comb begin
		link[0]            = '0;
		link[0].valid      = start && !busy;
		link[0].pixel      = pixel;
		link[0].best_d     = '1;
	end

	// One cell per palette entry. Cell 0 holds the fallback color and is
	// searched regardless of its valid bit.
	for (genvar i = 0; i < pq_pkg::PALETTE_ENTRIES; i++) begin : g_cell
		pq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (cfg_valid && cfg_ready
				&& (cfg_index == pq_pkg::CFG_IDX_W'(i))),
			.wr_data  (cfg_data),
			.anchor   (i == 0),
			.my_index (pq_pkg::IDX_W'(i)),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	// The winner must lie within its own threshold; otherwise the result
	// falls back to entry 0, whose color travels along the chain.
	assign fall = link[pq_pkg::PALETTE_ENTRIES].best_d
		> link[pq_pkg::PALETTE_ENTRIES].best_thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= link[pq_pkg::PALETTE_ENTRIES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fall) begin
			{result_q.out_blue, result_q.out_green, result_q.out_red}
				<= link[pq_pkg::PALETTE_ENTRIES].base_color;
			result_q.chosen_index <= '0;
		end else begin
			{result_q.out_blue, result_q.out_green, result_q.out_red}
				<= link[pq_pkg::PALETTE_ENTRIES].best_color;
			result_q.chosen_index <= link[pq_pkg::PALETTE_ENTRIES].best_idx;
		end
		result_q.fell_back <= fall;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/pq_checker.sv =====
// Port-level checker for the palette color quantizer, bound to the top level.
// Depends on pq_pkg.
module pq_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic            done,
	input  pq_pkg::result_t result
);

	// Every accepted request gives a result after the fixed latency.
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(pq_pkg::LATENCY) done)
		else $error("request produced no result at the expected cycle");

	// No result appears without a request accepted that many cycles earlier.
	a_no_orphan : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, pq_pkg::LATENCY))
		else $error("result without a matching request");

	// A fallback always reports entry 0.
	a_fallback_index : assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.fell_back) |-> (result.chosen_index == '0))
		else $error("fallback result with nonzero index");

	// The chosen entry is one that exists in the palette.
	a_index_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.chosen_index) < pq_pkg::PALETTE_ENTRIES))
		else $error("chosen index beyond the palette");

endmodule

bind palette_color_quantizer pq_checker u_pq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
